### src/sps_pkg.sv
// ----------------------------------------------------------------------------
// sps_pkg: shared types and constants for the sparse position symbol store
// Beat layouts for both channels, operation codes and store dimensions.
// ----------------------------------------------------------------------------
package sps_pkg;

    localparam int COND_LEN  = 32;
    localparam int POS_BITS  = $clog2(COND_LEN);
    localparam int SYM_BITS  = 8;
    localparam int CNT_BITS  = $clog2(COND_LEN + 1);
    localparam int KIND_BITS = 3;

    // operation codes
    localparam logic [KIND_BITS-1:0] KIND_INS_POS = 3'd0;
    localparam logic [KIND_BITS-1:0] KIND_INS_NTH = 3'd1;
    localparam logic [KIND_BITS-1:0] KIND_REM_POS = 3'd2;
    localparam logic [KIND_BITS-1:0] KIND_REM_NTH = 3'd3;
    localparam logic [KIND_BITS-1:0] KIND_NEXT    = 3'd4;

    typedef struct packed {
        logic [KIND_BITS-1:0] kind;
        logic [POS_BITS-1:0]  place;
        logic [SYM_BITS-1:0]  symbol;
    } t_in_beat;

    typedef struct packed {
        logic                ok;
        logic [POS_BITS-1:0] item_position;
        logic [SYM_BITS-1:0] item_symbol;
        logic [CNT_BITS-1:0] entry_count;
    } t_out_beat;

endpackage

### src/sparse_position_symbol_store.sv
// ----------------------------------------------------------------------------
// sparse_position_symbol_store: position-ordered sparse symbol map
// Valid bitmap plus symbol memory with rank/select and a read cursor.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in) carries one operation per
//   beat: insert at position, insert at n-th empty slot, remove at position,
//   remove n-th entry, or read next entry through the cursor. Output channel
//   (o_out_valid / i_out_ready / o_out) returns one result beat per operation.
//   One operation at a time; o_in_ready is high only while idle. A single scan
//   unit walks the 32-entry bitmap one position per cycle for every search.
//   From accept to result register: insert at position goes from execute
//   straight to finish; remove at position and next add one cursor scan
//   when an entry is removed or the cursor advances; insert n-th empty adds
//   one select scan; remove n-th entry adds a select scan and, on a match,
//   a cursor scan. The next beat is taken the cycle after the result register
//   loads, so a new operation is accepted only once the previous one has
//   reached the result register.
//   While the receiver stalls the result register holds its beat; one more
//   operation can be accepted and its result waits in the finish state.
//   Reset (i_rst_n low, synchronous) empties the map, clears the count and
//   parks the cursor at end. Symbol memory is not cleared; only entries
//   marked valid are ever read.
// ----------------------------------------------------------------------------
module sparse_position_symbol_store (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  sps_pkg::t_in_beat i_in,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output sps_pkg::t_out_beat o_out
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_FIN
    } t_state;

    // what the running scan is for
    typedef enum logic {
        PH_SELECT,  // rank/select of the operation itself
        PH_CURSOR   // relocating the cursor to the next valid entry
    } t_phase;

    typedef struct packed {
        logic                         ok;
        logic [sps_pkg::POS_BITS-1:0] pos;
        logic [sps_pkg::SYM_BITS-1:0] sym;
    } t_res;

    // control state
    t_state                          r_state,  n_state;
    logic [sps_pkg::COND_LEN-1:0]    r_map,    n_map;
    logic [sps_pkg::CNT_BITS-1:0]    r_count,  n_count;
    logic [sps_pkg::POS_BITS-1:0]    r_cursor, n_cursor;
    logic                            r_at_end, n_at_end;
    logic                            r_out_valid, n_out_valid;

    // payload
    sps_pkg::t_in_beat               r_in,     n_in;
    t_res                            r_res,    n_res;
    sps_pkg::t_out_beat              r_out,    n_out;
    logic [sps_pkg::POS_BITS-1:0]    r_idx,    n_idx;
    logic [sps_pkg::POS_BITS-1:0]    r_seen,   n_seen;
    logic [sps_pkg::POS_BITS-1:0]    r_rank,   n_rank;
    logic                            r_want,   n_want;
    t_phase                          r_phase,  n_phase;

    // symbol memory, registered read at the cursor
    logic [sps_pkg::SYM_BITS-1:0]    r_mem [sps_pkg::COND_LEN];
    logic [sps_pkg::SYM_BITS-1:0]    r_rd_sym;
    logic                            w_we;
    logic [sps_pkg::POS_BITS-1:0]    w_waddr;

    logic                            w_hit;
    logic                            w_in_fire;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign w_in_fire   = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // shared scan compare: does the current position match what we look for
    assign w_hit = (r_map[r_idx] == r_want);

    always_comb begin
        n_state     = r_state;
        n_map       = r_map;
        n_count     = r_count;
        n_cursor    = r_cursor;
        n_at_end    = r_at_end;
        n_out_valid = r_out_valid;
        n_in        = r_in;
        n_res       = r_res;
        n_out       = r_out;
        n_idx       = r_idx;
        n_seen      = r_seen;
        n_rank      = r_rank;
        n_want      = r_want;
        n_phase     = r_phase;
        w_we        = 1'b0;
        w_waddr     = r_in.place;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (w_in_fire) begin
                    n_in    = i_in;
                    n_state = ST_EXEC;
                end
            end

            ST_EXEC: begin
                n_res   = '0;
                n_state = ST_FIN;
                n_idx   = '0;
                n_seen  = '0;
                n_rank  = '0;
                n_want  = 1'b1;
                n_phase = PH_CURSOR;
                case (r_in.kind)
                    sps_pkg::KIND_INS_POS: begin
                        if (!r_map[r_in.place]) begin
                            w_we    = 1'b1;
                            w_waddr = r_in.place;
                            n_map[r_in.place] = 1'b1;
                            n_count = r_count + 1'b1;
                            if (r_count == '0) begin
                                n_cursor = r_in.place;
                                n_at_end = 1'b0;
                            end
                            n_res.ok  = 1'b1;
                            n_res.pos = r_in.place;
                        end
                    end
                    sps_pkg::KIND_INS_NTH: begin
                        n_want  = 1'b0;
                        n_rank  = r_in.place;
                        n_phase = PH_SELECT;
                        n_state = ST_SCAN;
                    end
                    sps_pkg::KIND_REM_POS: begin
                        if (r_map[r_in.place]) begin
                            n_map[r_in.place] = 1'b0;
                            n_count   = r_count - 1'b1;
                            n_res.ok  = 1'b1;
                            n_res.pos = r_in.place;
                            n_state   = ST_SCAN;
                        end
                    end
                    sps_pkg::KIND_REM_NTH: begin
                        n_rank  = r_in.place;
                        n_phase = PH_SELECT;
                        n_state = ST_SCAN;
                    end
                    sps_pkg::KIND_NEXT: begin
                        if (!r_at_end) begin
                            n_res.ok  = 1'b1;
                            n_res.pos = r_cursor;
                            n_res.sym = r_rd_sym;
                            if (r_cursor == '1) begin
                                n_cursor = '0;
                                n_at_end = 1'b1;
                            end else begin
                                n_idx   = r_cursor + 1'b1;
                                n_state = ST_SCAN;
                            end
                        end
                    end
                    default: begin
                        // unused codes answer with a failed beat
                    end
                endcase
            end

            ST_SCAN: begin
                if (w_hit && (r_seen == r_rank)) begin
                    if (r_phase == PH_CURSOR) begin
                        n_cursor = r_idx;
                        n_at_end = 1'b0;
                        n_state  = ST_FIN;
                    end else if (r_in.kind == sps_pkg::KIND_INS_NTH) begin
                        w_we     = 1'b1;
                        w_waddr  = r_idx;
                        n_map[r_idx] = 1'b1;
                        n_count  = r_count + 1'b1;
                        if (r_count == '0) begin
                            n_cursor = r_idx;
                            n_at_end = 1'b0;
                        end
                        n_res.ok  = 1'b1;
                        n_res.pos = r_idx;
                        n_state   = ST_FIN;
                    end else begin
                        // remove n-th: drop it, then rescan from zero for cursor
                        n_map[r_idx] = 1'b0;
                        n_count   = r_count - 1'b1;
                        n_res.ok  = 1'b1;
                        n_res.pos = r_idx;
                        n_idx     = '0;
                        n_seen    = '0;
                        n_rank    = '0;
                        n_want    = 1'b1;
                        n_phase   = PH_CURSOR;
                    end
                end else if (r_idx == '1) begin
                    // ran off the end without a match
                    if (r_phase == PH_CURSOR) begin
                        n_cursor = '0;
                        n_at_end = 1'b1;
                    end
                    n_state = ST_FIN;
                end else begin
                    n_idx = r_idx + 1'b1;
                    if (w_hit) begin
                        n_seen = r_seen + 1'b1;
                    end
                end
            end

            ST_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out.ok            = r_res.ok;
                    n_out.item_position = r_res.pos;
                    n_out.item_symbol   = r_res.sym;
                    n_out.entry_count   = r_count;
                    n_out_valid         = 1'b1;
                    n_state             = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_in    <= n_in;
        r_res   <= n_res;
        r_out   <= n_out;
        r_idx   <= n_idx;
        r_seen  <= n_seen;
        r_rank  <= n_rank;
        r_want  <= n_want;
        r_phase <= n_phase;
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_map       <= '0;
            r_count     <= '0;
            r_cursor    <= '0;
            r_at_end    <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_map       <= n_map;
            r_count     <= n_count;
            r_cursor    <= n_cursor;
            r_at_end    <= n_at_end;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= r_in.symbol;
        end
        r_rd_sym <= r_mem[r_cursor];
    end

    // ------------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------------
    a_count_matches_map: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> ($countones(r_map) == int'(r_count)))
        else $error("entry count out of step with valid map");

    a_cursor_on_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && !r_at_end) |-> r_map[r_cursor])
        else $error("cursor points at an empty position");

    a_empty_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && r_count == '0) |-> r_at_end)
        else $error("cursor live on an empty store");

    a_fail_is_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.ok) |->
            (r_out.item_position == '0 && r_out.item_symbol == '0))
        else $error("failed beat carries stale fields");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_fire |=> (r_state == ST_EXEC))
        else $error("accepted beat not taken into execution");

endmodule
